@@ hw/rtl/leb128_length_prefixed_framer_core_assert.svh @@
// Assertion helpers for the framer engine (lpf_engine).
// Each macro expects clk and rst_n in scope.
`ifndef LEB128_LENGTH_PREFIXED_FRAMER_CORE_ASSERT_SVH
`define LEB128_LENGTH_PREFIXED_FRAMER_CORE_ASSERT_SVH

// Same-cycle implication
`define LPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// Next-cycle implication
`define LPF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

@@ hw/rtl/lpf_pkg.sv @@
package lpf_pkg;

  // Payload buffer size; header length must stay below 128 (one LEB128 byte)
  localparam int PAYLOAD_BYTES = 32;
  localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);
  localparam int FILL_W        = $clog2(PAYLOAD_BYTES + 1);

  localparam logic [6:0] SEVEN_MASK = 7'h7F;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_VARINT = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  data_byte;
    logic [63:0] length_value;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

endpackage

@@ hw/rtl/leb128_length_prefixed_framer_core.sv @@
// Channel   Direction  Handshake                 Payload
// in_       input      push / full               in_cmd, in_data_byte, in_length_value
// out_      output     empty / pop               out_byte, out_last
//
// Each command is taken in ST_IDLE; a varint command then writes its 1 to 10 bytes in ST_VARINT.
// A frame is emitted as a header byte holding the fill, then the payload,
// one byte per cycle while the output queue has room, from the payload buffer's single read port.
// Two-entry queues on each side let input and output stall independently.
// Reset (rst_n low, synchronous) empties both queues and the payload buffer.
module leb128_length_prefixed_framer_core
  import lpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic [63:0] in_length_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  cmd_item_t cmd_item;
  logic      cmd_valid, cmd_pop;
  out_item_t push_item, head;
  logic      push_valid, push_ready;

  lpf_cmd_queue u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .full         (in_full),
    .cmd          (in_cmd),
    .data_byte    (in_data_byte),
    .length_value (in_length_value),
    .deq_valid    (cmd_valid),
    .deq          (cmd_pop),
    .deq_item     (cmd_item)
  );

  lpf_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd_item   (cmd_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  lpf_out_queue u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (push_valid),
    .enq_ready (push_ready),
    .enq_item  (push_item),
    .empty     (out_empty),
    .pop       (out_pop),
    .head      (head)
  );

  assign out_byte = head.out_byte;
  assign out_last = head.last;

endmodule

@@ hw/rtl/lpf_cmd_queue.sv @@
// Front end: takes commands, decodes the opcode, buffers two entries
module lpf_cmd_queue
  import lpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic [63:0] length_value,
  output logic        deq_valid,
  input  logic        deq,
  output cmd_item_t   deq_item
);

  cmd_item_t  entry_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       wr, rd;
  cmd_item_t  new_item;

  assign full      = (cnt_r == 2'd2);
  assign deq_valid = (cnt_r != 2'd0);
  assign deq_item  = entry_r[rd_ptr_r];
  assign wr        = push && !full;
  assign rd        = deq && deq_valid;
  assign cnt_nxt   = cnt_r + {1'b0, wr} - {1'b0, rd};

  // Decode; drop the fields a command does not use
  always_comb begin
    new_item.cmd          = cmd_t'(cmd);
    new_item.data_byte    = (new_item.cmd == CMD_BYTE)   ? data_byte    : 8'd0;
    new_item.length_value = (new_item.cmd == CMD_VARINT) ? length_value : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) wr_ptr_r <= !wr_ptr_r;
      if (rd) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) entry_r[wr_ptr_r] <= new_item;
  end

endmodule

@@ hw/rtl/lpf_out_queue.sv @@
// Result queue: two entries between the engine and the consumer
module lpf_out_queue
  import lpf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      enq_valid,
  output logic      enq_ready,
  input  out_item_t enq_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t head
);

  out_item_t  entry_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       wr, rd;

  assign enq_ready = (cnt_r != 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign head      = entry_r[rd_ptr_r];
  assign wr        = enq_valid && enq_ready;
  assign rd        = pop && !empty;
  assign cnt_nxt   = cnt_r + {1'b0, wr} - {1'b0, rd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) wr_ptr_r <= !wr_ptr_r;
      if (rd) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) entry_r[wr_ptr_r] <= enq_item;
  end

endmodule

@@ hw/rtl/lpf_engine.sv @@
// Back end: varint expansion, payload buffer and frame emission
module lpf_engine
  import lpf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  input  cmd_item_t cmd_item,
  output logic      push_valid,
  input  logic      push_ready,
  output out_item_t push_item
);

`include "leb128_length_prefixed_framer_core_assert.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_VARINT, ST_HDR, ST_DATA} state_t;

  state_t              st_r, st_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt, fill_inc;
  logic [ADDR_W-1:0]   idx_r, idx_nxt, last_idx;
  logic [63:0]         v_r, v_nxt, v_shift;
  logic                more_r, more_nxt;
  logic                at_full, is_last;
  logic                wr_en;
  logic [7:0]          wr_byte, vbyte;
  logic [7:0]          payload_store_r [PAYLOAD_BYTES];
  logic [7:0]          rd_data_r;

  assign fill_inc = fill_r + FILL_W'(1);
  assign at_full  = (fill_inc == FILL_W'(PAYLOAD_BYTES));
  assign v_shift  = v_r >> 7;
  assign vbyte    = {|v_shift, v_r[6:0] & SEVEN_MASK};
  assign last_idx = ADDR_W'(fill_r - FILL_W'(1));
  assign is_last  = (idx_r == last_idx);

  // Next-state logic
  always_comb begin
    st_nxt     = st_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    v_nxt      = v_r;
    more_nxt   = more_r;
    cmd_pop    = 1'b0;
    wr_en      = 1'b0;
    wr_byte    = vbyte;
    push_valid = 1'b0;
    push_item  = '{out_byte: rd_data_r, last: 1'b0};
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd_item.cmd)
            CMD_BYTE: begin
              wr_en    = 1'b1;
              wr_byte  = cmd_item.data_byte;
              fill_nxt = fill_inc;
              if (at_full) begin
                st_nxt   = ST_HDR;
                more_nxt = 1'b0;
              end
            end
            CMD_VARINT: begin
              v_nxt  = cmd_item.length_value;
              st_nxt = ST_VARINT;
            end
            CMD_FLUSH: begin
              if (fill_r != '0) begin
                st_nxt   = ST_HDR;
                more_nxt = 1'b0;
              end
            end
            CMD_CLEAR: fill_nxt = '0;
            default: ;
          endcase
        end
      end
      // one varint byte per cycle; a full buffer interrupts for a frame
      ST_VARINT: begin
        wr_en    = 1'b1;
        fill_nxt = fill_inc;
        v_nxt    = v_shift;
        if (at_full) begin
          st_nxt   = ST_HDR;
          more_nxt = |v_shift;
        end else if (v_shift == 64'd0) begin
          st_nxt = ST_IDLE;
        end
      end
      // length fits in one LEB128 byte; payload always follows
      ST_HDR: begin
        push_valid = 1'b1;
        push_item  = '{out_byte: 8'(fill_r), last: 1'b0};
        idx_nxt    = '0;
        if (push_ready) st_nxt = ST_DATA;
      end
      ST_DATA: begin
        push_valid = 1'b1;
        push_item  = '{out_byte: rd_data_r, last: is_last};
        if (push_ready) begin
          if (is_last) begin
            fill_nxt = '0;
            st_nxt   = more_r ? ST_VARINT : ST_IDLE;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      fill_r <= '0;
      more_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      more_r <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    v_r   <= v_nxt;
  end

  // Payload buffer: write at fill position, registered read at next index
  always_ff @(posedge clk) begin
    if (wr_en) payload_store_r[fill_r[ADDR_W-1:0]] <= wr_byte;
    rd_data_r <= payload_store_r[idx_nxt];
  end

  `LPF_ASSERT_IMP(a_write_room, wr_en, fill_r < FILL_W'(PAYLOAD_BYTES))
  `LPF_ASSERT_IMP(a_push_in_frame, push_valid, st_r == ST_HDR || st_r == ST_DATA)
  `LPF_ASSERT_IMP(a_idx_in_fill, st_r == ST_DATA, FILL_W'(idx_r) < fill_r)
  `LPF_ASSERT_NXT(a_frame_clears, st_r == ST_DATA && push_ready && is_last, fill_r == '0)

endmodule
